// ===== rtl/core/ahs_pkg.sv =====
// Shared types, character constants and helper functions for the
// ASCII hex mod-255 checksum block. No dependencies.
package ahs_pkg;

  localparam logic [7:0] Modulus  = 8'd255;
  localparam logic [7:0] StarChar = 8'h2A;

  localparam logic [2:0] VERDICT_GOOD     = 3'd0;
  localparam logic [2:0] VERDICT_SHORT    = 3'd1;
  localparam logic [2:0] VERDICT_NO_STAR  = 3'd2;
  localparam logic [2:0] VERDICT_BAD_HEX  = 3'd3;
  localparam logic [2:0] VERDICT_MISMATCH = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] verdict;
    logic [7:0] sum_value;
  } out_t;

  // Result of one frame step, handed from the frame tracker to the top level.
  typedef struct packed {
    logic       has_beat;
    out_t       beat;
    logic       suffix;
    logic [7:0] sum;
  } step_res_t;

  // Sum mod 255; inputs stay below 510, so one compare and subtract suffices.
  function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, Modulus}) begin
      t = t - {1'b0, Modulus};
    end
    return t[7:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return 8'h57 + {4'd0, nib};
  endfunction

  // Bit 4 set marks a byte that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      return {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      return {1'b0, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      return {1'b0, 4'(c - 8'h37)};
    end
    return 5'b10000;
  endfunction

endpackage

// ===== rtl/core/ascii_hex_sum_checksum.sv =====
// Top level of the ASCII hex mod-255 checksum block.
// Depends on ahs_pkg and ahs_frame.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one frame byte per
//   beat, with frame_end on the last byte of a frame. Output channel
//   (out_valid / out_stall / out_data) carries result beats.
//   cfg_we / cfg_wdata write the mode bit: 0 checks a trailing "*hh" suffix,
//   1 passes bytes through and appends "*hh" (lower-case hex of the sum).
//   Write the mode only while the block is idle.
// Path: a taken byte sits in the input register; its result beat, if any,
//   then sits in the output register, from which it is offered.
// Throughput: one byte per cycle while the output is not stalled. In
//   generate mode the last byte of a frame yields four beats, so the output
//   register holds off the input while the suffix drains. In check mode only
//   the last byte of a frame yields a beat; other bytes pass the input register
//   even while the output is stalled.
// Reset (rst_n low, synchronous): both registers empty, mode back to check,
//   frame state cleared. No clearing pass is needed.
// Stall: a stalled output beat holds; the input register keeps taking bytes
//   until it holds one that cannot move on, then in_stall rises.
module ascii_hex_sum_checksum
  import ahs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  logic       mode_r;
  logic       in_valid_r;
  in_t        in_data_r;
  logic       out_valid_r;
  out_t       out_r;
  logic [1:0] suf_cnt_r;
  logic [7:0] suf_sum_r;

  step_res_t  res;
  logic       out_free;
  logic       advance;
  logic       in_accept;
  logic       out_take;
  out_t       suf_beat;

  // Output slot is free next cycle if empty, or its beat leaves with no suffix left.
  assign out_free  = !out_valid_r || (!out_stall && (suf_cnt_r == 2'd0));
  assign advance   = in_valid_r && (!res.has_beat || out_free);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  ahs_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .mode  (mode_r),
    .item  (in_data_r),
    .res   (res)
  );

  // Suffix beats: star, then high digit, then low digit with the sum.
  always_comb begin
    suf_beat = '0;
    case (suf_cnt_r)
      2'd3: begin
        suf_beat.out_byte = StarChar;
      end
      2'd2: begin
        suf_beat.out_byte = hex_char(suf_sum_r[7:4]);
      end
      2'd1: begin
        suf_beat.out_byte  = hex_char(suf_sum_r[3:0]);
        suf_beat.out_last  = 1'b1;
        suf_beat.sum_value = suf_sum_r;
      end
      default: begin
        suf_beat = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      suf_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end

      // input register: load on accept, drop once the byte moves on
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      // output register: new beat, next suffix beat, or empty
      if (advance && res.has_beat) begin
        out_valid_r <= 1'b1;
        suf_cnt_r   <= res.suffix ? 2'd3 : 2'd0;
      end else if (out_take) begin
        if (suf_cnt_r != 2'd0) begin
          suf_cnt_r <= suf_cnt_r - 2'd1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
    end
    if (advance && res.has_beat) begin
      out_r     <= res.beat;
      suf_sum_r <= res.sum;
    end else if (out_take && (suf_cnt_r != 2'd0)) begin
      out_r <= suf_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/ahs_frame.sv =====
// Per-frame checksum state: running sum, three-byte check window, byte count.
// Depends on ahs_pkg.
module ahs_frame
  import ahs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      mode,
  input  in_t       item,
  output step_res_t res
);

  logic [7:0] win_r [3];
  logic [7:0] total_r;
  logic [1:0] seen_r;

  logic [7:0] win_nxt [3];
  logic [7:0] total_nxt;
  logic [1:0] seen_nxt;
  logic [7:0] gen_sum;
  logic [4:0] hi_val;
  logic [4:0] lo_val;
  logic [2:0] verdict;

  always_comb begin
    gen_sum    = mod_add(total_r, item.data_byte);
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = item.data_byte;
    if (seen_r == 2'd3) begin
      total_nxt = mod_add(total_r, win_r[0]);
      seen_nxt  = seen_r;
    end else begin
      total_nxt = total_r;
      seen_nxt  = seen_r + 2'd1;
    end
    hi_val = hex_value(win_nxt[1]);
    lo_val = hex_value(win_nxt[2]);
    if (seen_nxt != 2'd3) begin
      verdict = VERDICT_SHORT;
    end else if (win_nxt[0] != StarChar) begin
      verdict = VERDICT_NO_STAR;
    end else if (hi_val[4] || lo_val[4]) begin
      verdict = VERDICT_BAD_HEX;
    end else if ({hi_val[3:0], lo_val[3:0]} != total_nxt) begin
      verdict = VERDICT_MISMATCH;
    end else begin
      verdict = VERDICT_GOOD;
    end

    res = '0;
    if (mode) begin
      res.has_beat       = 1'b1;
      res.beat.out_byte  = item.data_byte;
      res.suffix         = item.frame_end;
      res.sum            = gen_sum;
    end else begin
      res.has_beat       = item.frame_end;
      res.beat.out_last  = 1'b1;
      res.beat.verdict   = verdict;
      res.beat.sum_value = (seen_nxt == 2'd3) ? total_nxt : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= '0;
      win_r[1] <= '0;
      win_r[2] <= '0;
      total_r  <= '0;
      seen_r   <= '0;
    end else if (step) begin
      if (item.frame_end) begin
        // clear the frame on its last byte
        win_r[0] <= '0;
        win_r[1] <= '0;
        win_r[2] <= '0;
        total_r  <= '0;
        seen_r   <= '0;
      end else if (mode) begin
        total_r <= gen_sum;
      end else begin
        win_r[0] <= win_nxt[0];
        win_r[1] <= win_nxt[1];
        win_r[2] <= win_nxt[2];
        total_r  <= total_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/ahs_checker.sv =====
// Port-level checks for the ASCII hex mod-255 checksum block, bound to its top.
// Depends on ahs_pkg.
module ahs_checker
  import ahs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // only the last beat of a frame carries a verdict or a sum
  a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_last |->
      out_data.verdict == VERDICT_GOOD && out_data.sum_value == 8'd0)
    else $error("verdict or sum on a beat that is not last");

  // a failed check is a check-mode beat: zero byte, sum below the modulus
  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != VERDICT_GOOD |->
      out_data.out_byte == 8'd0 && out_data.out_last && out_data.sum_value != Modulus)
    else $error("malformed failure beat");

endmodule

bind ascii_hex_sum_checksum ahs_checker u_ahs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/tb_ascii_hex_sum_checksum.sv =====
// Self-checking testbench for ascii_hex_sum_checksum: mod-255 sum with ASCII hex suffix.
// Depends on ahs_pkg and the RTL top level; carries its own behavioral predictor.
module tb_ascii_hex_sum_checksum;
  import ahs_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Idle margin after the last expected beat has drained, before a mode write or the final verdict.
  localparam int DRAIN_CYCLES = 6;
  // Cycles with no beat on either channel before the run is stopped as failed.
  localparam int HANG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  // Predictor state: mode, trailing three check-mode bytes ([0] oldest),
  // running sum of the covered bytes and how many bytes sit in the tail.
  logic       sum_mode;
  logic [7:0] tail_bytes[3];
  logic [7:0] frame_sum;
  logic [1:0] tail_fill;

  out_t expected_beats[$];
  int   mismatches = 0;
  int   hang_count = 0;

  // Shared between stimulus and the receiver process.
  logic calm = 1'b0;        // no sender gaps and no random receiver stalls while set; a requested hold-off still stalls
  int   hold_off_cycles = 0;

  ascii_hex_sum_checksum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] add255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    return 8'(t % 9'd255);
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return (upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
  endfunction

  // Value of a hex digit in either case; 16 flags anything else.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      return 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      return 5'(c - 8'h41 + 8'd10);
    end
    return 5'd16;
  endfunction

  function automatic void clear_frame();
    tail_bytes = '{8'd0, 8'd0, 8'd0};
    frame_sum  = 8'd0;
    tail_fill  = 2'd0;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic last,
                                    input logic [2:0] v, input logic [7:0] s);
    out_t r;
    r.out_byte  = b;
    r.out_last  = last;
    r.verdict   = v;
    r.sum_value = s;
    expected_beats.insert(expected_beats.size(), r);
  endfunction

  // Work out the beats one accepted input beat causes and queue them.
  function automatic void predict_beats(input in_t item);
    logic [7:0] s;
    logic [2:0] v;
    logic [4:0] hi;
    logic [4:0] lo;
    if (sum_mode) begin
      // Generate: pass the byte, then append "*hh" after the frame's last byte.
      frame_sum = add255(frame_sum, item.data_byte);
      push_beat(item.data_byte, 1'b0, VERDICT_GOOD, 8'd0);
      if (item.frame_end) begin
        s = frame_sum;
        push_beat(StarChar, 1'b0, VERDICT_GOOD, 8'd0);
        push_beat(hex_ascii(s[7:4], 1'b0), 1'b0, VERDICT_GOOD, 8'd0);
        push_beat(hex_ascii(s[3:0], 1'b0), 1'b1, VERDICT_GOOD, s);
        clear_frame();
      end
      return;
    end
    // Check: the oldest tail byte joins the sum once three are held back.
    if (tail_fill == 2'd3) begin
      frame_sum = add255(frame_sum, tail_bytes[0]);
    end else begin
      tail_fill = tail_fill + 2'd1;
    end
    tail_bytes[0] = tail_bytes[1];
    tail_bytes[1] = tail_bytes[2];
    tail_bytes[2] = item.data_byte;
    if (!item.frame_end) begin
      return;
    end
    s  = frame_sum;
    hi = digit_of(tail_bytes[1]);
    lo = digit_of(tail_bytes[2]);
    if (tail_fill != 2'd3) begin
      v = VERDICT_SHORT;
      s = 8'd0;
    end else if (tail_bytes[0] != StarChar) begin
      v = VERDICT_NO_STAR;
    end else if (hi[4] || lo[4]) begin
      v = VERDICT_BAD_HEX;
    end else if ({hi[3:0], lo[3:0]} != s) begin
      v = VERDICT_MISMATCH;
    end else begin
      v = VERDICT_GOOD;
    end
    push_beat(8'd0, 1'b1, v, s);
    clear_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_beat(input out_t got);
    out_t want;
    if (expected_beats.size() == 0) begin
      $error("unexpected result beat %0h", got);
      mismatches++;
      return;
    end
    want = expected_beats.pop_front();
    compare_field("out_byte", want.out_byte, got.out_byte);
    compare_field("out_last", 8'(want.out_last), 8'(got.out_last));
    compare_field("verdict", 8'(want.verdict), 8'(got.verdict));
    compare_field("sum_value", want.sum_value, got.sum_value);
  endtask

  // Sample both channels and the mode write on the rising edge; predict before
  // checking, since no result can come from a byte taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      sum_mode = 1'b0;
      clear_frame();
    end else begin
      if (cfg_we) begin
        sum_mode = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        predict_beats(in_data);
      end
      if (out_valid && !out_stall) begin
        check_beat(out_data);
      end
    end
  end

  // Hang detector: count edges with no beat moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_count = 0;
      end else begin
        hang_count++;
      end
      if (hang_count >= HANG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int pick_len();
    if ($urandom_range(0, 19) < 17) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    return pick_len();
  endfunction

  // Receiver: drive out_stall at the falling edge. A requested hold-off wins,
  // then calm stretches, then random stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (calm) begin
        out_stall  <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_len();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (entered and left at a falling edge)
  // ---------------------------------------------------------------------------
  // Offer one byte and hold it until it is taken; leave valid high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{data_byte: b, frame_end: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t fb);
    foreach (fb[i]) begin
      send_byte(fb[i], i == fb.size() - 1);
    end
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Extremes and the suffix character show up more often than pure chance gives.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return StarChar;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Check mode straight out of reset: every verdict, the good one in both letter cases.
  task automatic test_check_directed();
    byte_q_t fb;
    fb = '{8'h2A, 8'h30};                       // under three bytes
    send_frame(fb);
    fb = '{8'hFF, 8'hFE, 8'h2A, 8'h66, 8'h65};  // good, lower case "fe"
    send_frame(fb);
    fb = '{8'hC3, 8'h2A, 8'h43, 8'h33};         // good, upper case "C3"
    send_frame(fb);
    fb = '{8'h2B, 8'h30, 8'h30};                // no star
    send_frame(fb);
    fb = '{8'h2A, 8'h47, 8'h30};                // bad high digit
    send_frame(fb);
    fb = '{8'h2A, 8'h30, 8'h31};                // bare suffix, sum 0 vs 01
    send_frame(fb);
  endtask

  task automatic test_generate_directed();
    byte_q_t fb;
    set_mode(1'b1);
    fb = '{8'h00, 8'hFF, 8'h80, 8'h7F};  // wraps back to a zero sum
    send_frame(fb);
    fb = '{8'hAB};                       // one-byte frame, letter digits
    send_frame(fb);
  endtask

  // Switch mode inside a frame both ways; the last byte picks the output form.
  task automatic test_mode_switch_mid_frame();
    byte_q_t fb;
    send_byte(8'h10, 1'b0);
    set_mode(1'b0);
    fb = '{8'h2A, 8'h31, 8'h30};
    send_frame(fb);
    send_byte(8'h05, 1'b0);
    set_mode(1'b1);
    send_byte(8'h06, 1'b1);
  endtask

  task automatic test_random_generate(input int n_items);
    byte_q_t fb;
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 5) == 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      fb   = {};
      repeat (len) fb.insert(fb.size(), random_byte());
      send_frame(fb);
      sent += fb.size();
    end
    calm = 1'b0;
  endtask

  // Mostly well-formed frames with random bodies; the rest broken or noise.
  task automatic test_random_check(input int n_items);
    byte_q_t fb;
    int sent;
    int kind;
    int len;
    logic [7:0] s;
    logic [7:0] code;
    logic [7:0] bad;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
      fb   = {};
      s    = 8'd0;
      repeat (len) begin
        fb.insert(fb.size(), random_byte());
        s = add255(s, fb[fb.size() - 1]);
      end
      if (kind == 9) begin
        // noise: raw bytes, often too short for a suffix
        fb = {};
        repeat ($urandom_range(1, 5)) fb.insert(fb.size(), random_byte());
      end else begin
        code = (kind == 8) ? s + 8'($urandom_range(1, 255)) : s;
        if (kind == 6) begin
          do bad = 8'($urandom_range(0, 255)); while (bad == StarChar);
          fb.insert(fb.size(), bad);
        end else begin
          fb.insert(fb.size(), StarChar);
        end
        fb.insert(fb.size(), hex_ascii(code[7:4], 1'($urandom_range(0, 1))));
        fb.insert(fb.size(), hex_ascii(code[3:0], 1'($urandom_range(0, 1))));
        if (kind == 7) begin
          do bad = 8'($urandom_range(0, 255)); while (digit_of(bad) < 5'd16);
          fb[fb.size() - 1 - $urandom_range(0, 1)] = bad;
        end
      end
      send_frame(fb);
      sent += fb.size();
    end
    calm = 1'b0;
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming gapless,
  // so the block fills and raises in_stall.
  task automatic test_backpressure();
    byte_q_t fb;
    set_mode(1'b1);
    calm            = 1'b1;
    hold_off_cycles = 80;
    repeat (5) begin
      fb = {};
      repeat (8) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
      send_frame(fb);
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_check_directed();
    test_generate_directed();
    test_mode_switch_mid_frame();

    set_mode(1'b0);
    test_random_check(120);
    set_mode(1'b1);
    test_random_generate(90);
    test_backpressure();
    set_mode(1'b0);
    test_random_check(110);
    set_mode(1'b1);
    test_random_generate(40);

    wait_drained();
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ahs_pkg.sv
rtl/core/ahs_frame.sv
rtl/core/ascii_hex_sum_checksum.sv
rtl/core/ahs_checker.sv
tb/sv/tb_ascii_hex_sum_checksum.sv
